// ===== design/ole_pkg.sv =====
// ole_pkg: shared types and constants for the ordered list engine
// no dependencies; imported by ole_ram users and by ordered_list_engine
`default_nettype none
package ole_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 3'd0,
        KIND_REMOVE  = 3'd1,
        KIND_READ    = 3'd2,
        KIND_FIND    = 3'd3,
        KIND_COUNT   = 3'd4,
        KIND_REVERSE = 3'd5,
        KIND_CLEAR   = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_ERR  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_READ_RD,
        S_READ_WAIT,
        S_SCAN,
        S_REV_A,
        S_REV_B,
        S_REV_C,
        S_REV_D
    } state_t;

endpackage
`default_nettype wire

// ===== design/ole_ram.sv =====
// ole_ram: generic single write port, single read port memory
// registered read data; no dependencies
`default_nettype none
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/ordered_list_engine.sv =====
// ordered_list_engine: bounded ordered list held in one memory plus an entry count
// depends on ole_pkg and ole_ram
//
//  channel   signals                                       handshake
//  command   start, kind, position_in, operand             start && !busy
//  result    done, status, read_value, found_at,           done, one cycle,
//            match_total, length                           no back-pressure
//
// the block works on one item at a time through the single memory port pair:
// clear, errors and trivial cases finish straight from idle, read takes a read
// and a wait step, find and count scan every entry, insert shifts entries up from
// the back towards pos, remove closes the gap front to back, reverse swaps pairs.
// the result strobe is registered and rises in the cycle after the last step; busy falls with it.
// reset clears the count and control only; entries stay unwritten.
`default_nettype none
module ordered_list_engine #(
    parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic        [ole_pkg::KIND_W-1:0] kind,
    input  wire logic        [ole_pkg::POS_W-1:0]  position_in,
    input  wire logic signed [ole_pkg::VAL_W-1:0]  operand,
    output logic                                   done,
    output logic        [ole_pkg::STATUS_W-1:0]    status,
    output logic signed [ole_pkg::VAL_W-1:0]       read_value,
    output logic signed [ole_pkg::CNT_W-1:0]       found_at,
    output logic        [ole_pkg::CNT_W-1:0]       match_total,
    output logic        [ole_pkg::CNT_W-1:0]       length
);

    import ole_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [PW-1:0] ONE = PW'(1);
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [PW-1:0]     idx_reg, idx_next;
    logic [PW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [VAL_W-1:0]  tmp_reg, tmp_next;

    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    logic [PW-1:0]     hidx_reg, hidx_next;
    logic [PW-1:0]     acc_reg, acc_next;

    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [VAL_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]  total_reg, total_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;

    logic [PW-1:0]     cnt_w;
    logic [PW-1:0]     pos_in_w;
    logic              match;
    logic [PW-1:0]     acc_upd;
    logic              hit_upd;
    logic [PW-1:0]     hidx_upd;

    ole_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cnt_w    = PW'(count_reg);
    assign pos_in_w = PW'(position_in);

    // scan compare on the data read in the previous cycle
    assign match    = pend_reg && (ram_rdata == val_reg);
    assign acc_upd  = acc_reg + PW'(match);
    assign hit_upd  = hit_reg || match;
    assign hidx_upd = (match && !hit_reg) ? idx_reg - ONE : hidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        hi_reg     <= hi_next;
        tmp_reg    <= tmp_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        found_reg  <= found_next;
        total_reg  <= total_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        hi_next     = hi_reg;
        count_next  = count_reg;
        tmp_next    = tmp_reg;
        pend_next   = 1'b0;
        hit_next    = hit_reg;
        hidx_next   = hidx_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rd_next     = rd_reg;
        found_next  = found_reg;
        total_next  = total_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = kind_t'(kind);
                    pos_next    = pos_in_w;
                    val_next    = operand;
                    status_next = ST_DONE;
                    rd_next     = '0;
                    found_next  = '0;
                    total_next  = '0;
                    hit_next    = 1'b0;
                    hidx_next   = '0;
                    acc_next    = '0;
                    case (kind)
                        KIND_INSERT:
                        begin
                            if (pos_in_w > cnt_w)
                            begin
                                status_next = ST_ERR;
                                done_next   = 1'b1;
                            end
                            else if (cnt_w == DEPTH_P)
                            begin
                                status_next = ST_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                idx_next   = cnt_w;
                                state_next = (pos_in_w == cnt_w) ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (pos_in_w >= cnt_w)
                            begin
                                status_next = ST_ERR;
                                done_next   = 1'b1;
                            end
                            else if (pos_in_w + ONE == cnt_w)
                            begin
                                // last entry: nothing to close up
                                count_next = count_reg - CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                idx_next   = pos_in_w;
                                state_next = S_REM_RD;
                            end
                        end
                        KIND_READ:
                        begin
                            if (pos_in_w >= cnt_w)
                            begin
                                status_next = ST_ERR;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                idx_next   = pos_in_w;
                                state_next = S_READ_RD;
                            end
                        end
                        KIND_FIND, KIND_COUNT:
                        begin
                            if (count_reg == '0)
                            begin
                                found_next = (kind == KIND_FIND) ? '1 : '0;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        KIND_REVERSE:
                        begin
                            if (cnt_w < PW'(2))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                hi_next    = cnt_w - ONE;
                                state_next = S_REV_A;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_ERR;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            // shift up one entry a pass, from the back towards pos
            S_INS_RD:
            begin
                ram_raddr  = AW'(idx_reg - ONE);
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg - ONE;
                state_next = (idx_reg - ONE == pos_reg) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // close the gap, front to back
            S_REM_RD:
            begin
                ram_raddr  = AW'(idx_reg + ONE);
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + ONE;
                if (idx_reg + PW'(2) == cnt_w)
                begin
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_REM_RD;
                end
            end

            S_READ_RD:
            begin
                ram_raddr  = pos_reg[AW-1:0];
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                rd_next    = ram_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // one read issued a cycle, each compared in the cycle after its read
            S_SCAN:
            begin
                acc_next  = acc_upd;
                hit_next  = hit_upd;
                hidx_next = hidx_upd;
                if (idx_reg != cnt_w)
                begin
                    ram_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + ONE;
                    pend_next = 1'b1;
                end
                else
                begin
                    if (kind_reg == KIND_FIND)
                    begin
                        found_next = hit_upd ? hidx_upd[CNT_W-1:0] : '1;
                    end
                    else
                    begin
                        total_next = acc_upd[CNT_W-1:0];
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // swap the entries at idx (low end) and hi
            S_REV_A:
            begin
                ram_raddr  = idx_reg[AW-1:0];
                state_next = S_REV_B;
            end
            S_REV_B:
            begin
                ram_raddr  = hi_reg[AW-1:0];
                tmp_next   = ram_rdata;
                state_next = S_REV_C;
            end
            S_REV_C:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                state_next = S_REV_D;
            end
            S_REV_D:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg[AW-1:0];
                ram_wdata = tmp_reg;
                idx_next  = idx_reg + ONE;
                hi_next   = hi_reg - ONE;
                if (idx_reg + ONE < hi_reg - ONE)
                begin
                    state_next = S_REV_A;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = rd_reg;
    assign found_at    = found_reg;
    assign match_total = total_reg;
    assign length      = cnt_w[CNT_W-1:0];

endmodule
`default_nettype wire
